/* rtl/core/cmta_pkg.sv */
package cmta_pkg;

  localparam int unsigned DIR_BITS_DEF      = 16;
  localparam int unsigned MAX_FACE_SIZE_DEF = 4096;

  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned BPP_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FACE_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FACE_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;

  localparam logic [CFG_DATA_W-1:0] FACE_WIDTH_RST  = 13'd256;
  localparam logic [CFG_DATA_W-1:0] FACE_HEIGHT_RST = 13'd256;
  localparam logic [BPP_W-1:0]      BPP_RST         = 3'd3;
  localparam logic [BPP_W-1:0]      BPP_RGBA        = 3'd4;

  localparam int unsigned FACE_W   = 3;
  localparam int unsigned TEXEL_W  = 12;
  localparam int unsigned OFFSET_W = 26;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_PTR_W = 2;
  localparam int unsigned QUEUE_CNT_W = 3;

  typedef enum logic [FACE_W-1:0] {
    FACE_RIGHT  = 3'd0,
    FACE_LEFT   = 3'd1,
    FACE_TOP    = 3'd2,
    FACE_BOTTOM = 3'd3,
    FACE_FRONT  = 3'd4,
    FACE_BACK   = 3'd5
  } face_e;

  typedef struct packed {
    face_e face;
    logic  background;
  } ctrl_t;

endpackage

/* rtl/core/cmta_front.sv */
module cmta_front #(
  parameter int unsigned DIR_BITS = cmta_pkg::DIR_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic signed [DIR_BITS-1:0] dir_x_i,
  input  logic signed [DIR_BITS-1:0] dir_y_i,
  input  logic signed [DIR_BITS-1:0] dir_z_i,
  output logic                       valid_o,
  output cmta_pkg::ctrl_t            ctrl_o,
  output logic [DIR_BITS-1:0]        ma_o,
  output logic [DIR_BITS:0]          span_s_o,
  output logic [DIR_BITS:0]          span_t_o
);

  logic                  valid_q;
  cmta_pkg::ctrl_t       ctrl_q, ctrl_d;
  logic [DIR_BITS-1:0]   ma_q, ma_d;
  logic [DIR_BITS:0]     span_s_q, span_s_d;
  logic [DIR_BITS:0]     span_t_q, span_t_d;

  logic [DIR_BITS-1:0]   ax, ay, az;
  logic                  zero_dir;
  logic signed [DIR_BITS-1:0] sc_c, tc_c;
  logic                  sc_neg, tc_neg;

  function automatic logic [DIR_BITS:0] span_of(
    input logic [DIR_BITS-1:0]        ma,
    input logic signed [DIR_BITS-1:0] c,
    input logic                       neg
  );
    logic signed [DIR_BITS+1:0] ce;
    logic signed [DIR_BITS+1:0] me;
    logic signed [DIR_BITS+1:0] s;
    ce = {{2{c[DIR_BITS-1]}}, c};
    me = $signed({2'b00, ma});
    s  = neg ? (me - ce) : (me + ce);
    return s[DIR_BITS:0];
  endfunction

  assign ax = dir_x_i[DIR_BITS-1] ? DIR_BITS'(-dir_x_i) : DIR_BITS'(dir_x_i);
  assign ay = dir_y_i[DIR_BITS-1] ? DIR_BITS'(-dir_y_i) : DIR_BITS'(dir_y_i);
  assign az = dir_z_i[DIR_BITS-1] ? DIR_BITS'(-dir_z_i) : DIR_BITS'(dir_z_i);
  assign zero_dir = (dir_x_i == '0) && (dir_y_i == '0) && (dir_z_i == '0);

  always_comb begin
    if (ax > ay) begin
      ma_d        = ax;
      ctrl_d.face = dir_x_i[DIR_BITS-1] ? cmta_pkg::FACE_RIGHT : cmta_pkg::FACE_LEFT;
    end else begin
      ma_d        = ay;
      ctrl_d.face = dir_y_i[DIR_BITS-1] ? cmta_pkg::FACE_BOTTOM : cmta_pkg::FACE_TOP;
    end
    if (az > ma_d) begin
      ma_d        = az;
      ctrl_d.face = dir_z_i[DIR_BITS-1] ? cmta_pkg::FACE_BACK : cmta_pkg::FACE_FRONT;
    end
    ctrl_d.background = zero_dir;

    case (ctrl_d.face)
      cmta_pkg::FACE_RIGHT: begin
        sc_c = dir_z_i; sc_neg = 1'b1; tc_c = dir_y_i; tc_neg = 1'b0;
      end
      cmta_pkg::FACE_LEFT: begin
        sc_c = dir_z_i; sc_neg = 1'b0; tc_c = dir_y_i; tc_neg = 1'b0;
      end
      cmta_pkg::FACE_TOP: begin
        sc_c = dir_x_i; sc_neg = 1'b1; tc_c = dir_z_i; tc_neg = 1'b1;
      end
      cmta_pkg::FACE_BOTTOM: begin
        sc_c = dir_x_i; sc_neg = 1'b1; tc_c = dir_z_i; tc_neg = 1'b0;
      end
      cmta_pkg::FACE_FRONT: begin
        sc_c = dir_x_i; sc_neg = 1'b1; tc_c = dir_y_i; tc_neg = 1'b0;
      end
      default: begin
        sc_c = dir_x_i; sc_neg = 1'b0; tc_c = dir_y_i; tc_neg = 1'b0;
      end
    endcase

    span_s_d = span_of(ma_d, sc_c, sc_neg);
    span_t_d = span_of(ma_d, tc_c, tc_neg);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ctrl_q   <= ctrl_d;
      ma_q     <= ma_d;
      span_s_q <= span_s_d;
      span_t_q <= span_t_d;
    end
  end

  assign valid_o  = valid_q;
  assign ctrl_o   = ctrl_q;
  assign ma_o     = ma_q;
  assign span_s_o = span_s_q;
  assign span_t_o = span_t_q;

endmodule

/* rtl/core/cmta_queue.sv */
module cmta_queue #(
  parameter int unsigned DATA_W = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [DATA_W-1:0]                data_i,
  input  logic                             pop_i,
  output logic [DATA_W-1:0]                data_o,
  output logic                             empty_o,
  output logic [cmta_pkg::QUEUE_CNT_W-1:0] count_o
);

  logic [DATA_W-1:0]                mem_q [cmta_pkg::QUEUE_DEPTH];
  logic [cmta_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [cmta_pkg::QUEUE_CNT_W-1:0] count_q, count_d;
  logic                             do_pop;

  assign do_pop = pop_i && (count_q != '0);

  always_comb begin
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

/* rtl/core/cmta_div.sv */
module cmta_div #(
  parameter int unsigned NUM_W = 30,
  parameter int unsigned DEN_W = 17,
  parameter int unsigned QUO_W = 12
) (
  input  logic             clk_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    localparam int unsigned B = QUO_W - 1 - i;
    logic [NUM_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [NUM_W-1:0] den_sh;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign den_in = den_q[i-1];
      assign quo_in = quo_q[i-1];
    end

    assign den_sh = NUM_W'(den_in) << B;
    assign ge     = (rem_in >= den_sh);

    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? (rem_in - den_sh) : rem_in;
      den_q[i] <= den_in;
      quo_q[i] <= ge ? (quo_in | (QUO_W'(1) << B)) : quo_in;
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

/* rtl/core/cmta_back.sv */
module cmta_back #(
  parameter int unsigned DIR_BITS = cmta_pkg::DIR_BITS_DEF,
  parameter int unsigned SIZE_W   = 13,
  parameter int unsigned QUO_W    = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  cmta_pkg::ctrl_t                 ctrl_i,
  input  logic [DIR_BITS-1:0]             ma_i,
  input  logic [DIR_BITS:0]               span_s_i,
  input  logic [DIR_BITS:0]               span_t_i,
  input  logic [SIZE_W-1:0]               width_i,
  input  logic [SIZE_W-1:0]               height_i,
  input  logic                            bpp4_i,
  output logic                            done_o,
  output logic [cmta_pkg::FACE_W-1:0]     face_o,
  output logic [cmta_pkg::TEXEL_W-1:0]    texel_x_o,
  output logic [cmta_pkg::TEXEL_W-1:0]    texel_y_o,
  output logic [cmta_pkg::OFFSET_W-1:0]   byte_offset_o,
  output logic                            background_o
);

  localparam int unsigned DEN_W    = DIR_BITS + 1;
  localparam int unsigned NUM_W    = SIZE_W + DIR_BITS + 1;
  localparam int unsigned PROD_W   = QUO_W + SIZE_W;
  localparam int unsigned SUM_W    = PROD_W + 1;
  localparam int unsigned OFF_W    = SUM_W + 2;
  localparam int unsigned OFF_FW   = (OFF_W > cmta_pkg::OFFSET_W) ? OFF_W : cmta_pkg::OFFSET_W;
  localparam int unsigned TEX_FW   = (QUO_W > cmta_pkg::TEXEL_W) ? QUO_W : cmta_pkg::TEXEL_W;
  localparam int unsigned PIPE_LEN = QUO_W + 2;

  logic                 mul_vld_q;
  cmta_pkg::ctrl_t      mul_ctrl_q;
  logic [NUM_W-1:0]     num_s_q, num_t_q;
  logic [DEN_W-1:0]     den_q;

  logic [QUO_W-1:0]     tx, ty;

  logic                 vld_q  [PIPE_LEN];
  cmta_pkg::ctrl_t      ctrl_q [PIPE_LEN];

  logic [PROD_W-1:0]    prod_q;
  logic [QUO_W-1:0]     tx1_q, tx2_q, ty1_q, ty2_q;
  logic [SUM_W-1:0]     sum_q;
  logic [OFF_W-1:0]     off_d;
  logic [OFF_FW-1:0]    off_full;
  logic [TEX_FW-1:0]    tx_full, ty_full;

  logic                                done_q;
  logic [cmta_pkg::FACE_W-1:0]         face_q;
  logic [cmta_pkg::TEXEL_W-1:0]        texel_x_q, texel_y_q;
  logic [cmta_pkg::OFFSET_W-1:0]       byte_offset_q;
  logic                                background_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    mul_ctrl_q <= ctrl_i;
    num_s_q    <= NUM_W'(width_i - 1'b1) * NUM_W'(span_s_i);
    num_t_q    <= NUM_W'(height_i - 1'b1) * NUM_W'(span_t_i);
    den_q      <= {ma_i, 1'b0};
  end

  cmta_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (QUO_W)
  ) u_div_x (
    .clk_i (clk_i),
    .num_i (num_s_q),
    .den_i (den_q),
    .quo_o (tx)
  );

  cmta_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W),
    .QUO_W (QUO_W)
  ) u_div_y (
    .clk_i (clk_i),
    .num_i (num_t_q),
    .den_i (den_q),
    .quo_o (ty)
  );

  for (genvar i = 0; i < PIPE_LEN; i++) begin : g_side
    logic            vld_in;
    cmta_pkg::ctrl_t ctrl_in;
    if (i == 0) begin : g_first
      assign vld_in  = mul_vld_q;
      assign ctrl_in = mul_ctrl_q;
    end else begin : g_next
      assign vld_in  = vld_q[i-1];
      assign ctrl_in = ctrl_q[i-1];
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else begin
        vld_q[i] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      ctrl_q[i] <= ctrl_in;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(ty) * PROD_W'(width_i);
    tx1_q  <= tx;
    ty1_q  <= ty;
    sum_q  <= SUM_W'(prod_q) + SUM_W'(tx1_q);
    tx2_q  <= tx1_q;
    ty2_q  <= ty1_q;
  end

  assign off_d    = bpp4_i ? (OFF_W'(sum_q) << 2) : (OFF_W'(sum_q) + (OFF_W'(sum_q) << 1));
  assign off_full = OFF_FW'(off_d);
  assign tx_full  = TEX_FW'(tx2_q);
  assign ty_full  = TEX_FW'(ty2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[PIPE_LEN-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_q[PIPE_LEN-1].background) begin
      face_q        <= '0;
      texel_x_q     <= '0;
      texel_y_q     <= '0;
      byte_offset_q <= '0;
      background_q  <= 1'b1;
    end else begin
      face_q        <= ctrl_q[PIPE_LEN-1].face;
      texel_x_q     <= tx_full[cmta_pkg::TEXEL_W-1:0];
      texel_y_q     <= ty_full[cmta_pkg::TEXEL_W-1:0];
      byte_offset_q <= off_full[cmta_pkg::OFFSET_W-1:0];
      background_q  <= 1'b0;
    end
  end

  assign done_o        = done_q;
  assign face_o        = face_q;
  assign texel_x_o     = texel_x_q;
  assign texel_y_o     = texel_y_q;
  assign byte_offset_o = byte_offset_q;
  assign background_o  = background_q;

endmodule

/* rtl/core/cube_map_texel_address_unit.sv */
// throughput: one transaction per cycle, set by the one-bit-per-stage quotient pipelines
// busy stays low: the back end pops the classify queue whenever it is not empty; the receiver cannot stall
// reset: asynchronous, active low; clears all valid bits and the queue, and sets
// face width and height to 256 and bytes per pixel to 3
module cube_map_texel_address_unit #(
  parameter int unsigned MAX_FACE_SIZE = cmta_pkg::MAX_FACE_SIZE_DEF,
  parameter int unsigned DIR_BITS      = cmta_pkg::DIR_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [DIR_BITS-1:0]          dir_x_i,
  input  logic signed [DIR_BITS-1:0]          dir_y_i,
  input  logic signed [DIR_BITS-1:0]          dir_z_i,
  input  logic                                cfg_we_i,
  input  logic [cmta_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [cmta_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output logic                                done_o,
  output logic [cmta_pkg::FACE_W-1:0]         face_o,
  output logic [cmta_pkg::TEXEL_W-1:0]        texel_x_o,
  output logic [cmta_pkg::TEXEL_W-1:0]        texel_y_o,
  output logic [cmta_pkg::OFFSET_W-1:0]       byte_offset_o,
  output logic                                background_o
);

  localparam int unsigned SIZE_W = $clog2(MAX_FACE_SIZE + 1);
  localparam int unsigned QUO_W  = $clog2(MAX_FACE_SIZE);
  localparam int unsigned CMP_W  = (SIZE_W > cmta_pkg::CFG_DATA_W) ? SIZE_W
                                                                   : cmta_pkg::CFG_DATA_W;
  localparam int unsigned CTRL_W = $bits(cmta_pkg::ctrl_t);
  localparam int unsigned ENTRY_W = CTRL_W + DIR_BITS + 2 * (DIR_BITS + 1);

  logic [cmta_pkg::CFG_DATA_W-1:0] width_q, height_q;
  logic [cmta_pkg::BPP_W-1:0]      bpp_q;
  logic [SIZE_W-1:0]               eff_width, eff_height;

  logic                            accept;
  logic                            fr_valid;
  cmta_pkg::ctrl_t                 fr_ctrl, bk_ctrl;
  logic [DIR_BITS-1:0]             fr_ma, bk_ma;
  logic [DIR_BITS:0]               fr_span_s, fr_span_t, bk_span_s, bk_span_t;
  logic [ENTRY_W-1:0]              q_wdata, q_rdata;
  logic                            q_empty;
  logic [cmta_pkg::QUEUE_CNT_W-1:0] q_count;

  function automatic logic [SIZE_W-1:0] eff_size(input logic [cmta_pkg::CFG_DATA_W-1:0] r);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(r);
    if (ext == '0) begin
      return SIZE_W'(1);
    end else if (ext > CMP_W'(MAX_FACE_SIZE)) begin
      return SIZE_W'(MAX_FACE_SIZE);
    end
    return SIZE_W'(ext);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= cmta_pkg::FACE_WIDTH_RST;
      height_q <= cmta_pkg::FACE_HEIGHT_RST;
      bpp_q    <= cmta_pkg::BPP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cmta_pkg::REG_FACE_WIDTH:      width_q  <= cfg_wdata_i;
        cmta_pkg::REG_FACE_HEIGHT:     height_q <= cfg_wdata_i;
        cmta_pkg::REG_BYTES_PER_PIXEL: bpp_q    <= cfg_wdata_i[cmta_pkg::BPP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign eff_width  = eff_size(width_q);
  assign eff_height = eff_size(height_q);

  assign busy   = (q_count >= cmta_pkg::QUEUE_CNT_W'(cmta_pkg::QUEUE_DEPTH - 1));
  assign accept = start && !busy;

  cmta_front #(
    .DIR_BITS (DIR_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .dir_x_i  (dir_x_i),
    .dir_y_i  (dir_y_i),
    .dir_z_i  (dir_z_i),
    .valid_o  (fr_valid),
    .ctrl_o   (fr_ctrl),
    .ma_o     (fr_ma),
    .span_s_o (fr_span_s),
    .span_t_o (fr_span_t)
  );

  assign q_wdata = {fr_ctrl, fr_ma, fr_span_s, fr_span_t};

  cmta_queue #(
    .DATA_W (ENTRY_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fr_valid),
    .data_i  (q_wdata),
    .pop_i   (!q_empty),
    .data_o  (q_rdata),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  assign {bk_ctrl, bk_ma, bk_span_s, bk_span_t} = q_rdata;

  cmta_back #(
    .DIR_BITS (DIR_BITS),
    .SIZE_W   (SIZE_W),
    .QUO_W    (QUO_W)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (!q_empty),
    .ctrl_i        (bk_ctrl),
    .ma_i          (bk_ma),
    .span_s_i      (bk_span_s),
    .span_t_i      (bk_span_t),
    .width_i       (eff_width),
    .height_i      (eff_height),
    .bpp4_i        (bpp_q == cmta_pkg::BPP_RGBA),
    .done_o        (done_o),
    .face_o        (face_o),
    .texel_x_o     (texel_x_o),
    .texel_y_o     (texel_y_o),
    .byte_offset_o (byte_offset_o),
    .background_o  (background_o)
  );

endmodule
